@@ src/ypcb_pkg.sv @@
// Types, constants and the arctangent table shared by the camera basis block.
package ypcb_pkg;

	// CORDIC datapath widths: Q1.30 vector with headroom, 32-bit phase in turns
	localparam int XW = 34;
	localparam int ZW = 32;
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [XW-1:0] CORDIC_X0   = XW'(652032874);
	localparam logic signed [15:0]   PITCH_LIMIT = 16'sd16169;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [ZW-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// configuration register indexes
	localparam logic [1:0] REG_EYE_OFFSET_X = 2'd0;
	localparam logic [1:0] REG_EYE_OFFSET_Y = 2'd1;
	localparam logic [1:0] REG_EYE_OFFSET_Z = 2'd2;

	// quadrant codes: top two bits of the phase
	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	// what one cell of the rotation chain holds
	typedef struct packed {
		rot_t       yaw;
		rot_t       pitch;
		logic [1:0] yaw_quad;
		logic [1:0] pitch_quad;
		vec3_t      eye;
	} lane_t;

	typedef struct packed {
		logic signed [31:0] body_x;
		logic signed [31:0] body_y;
		logic signed [31:0] body_z;
		logic        [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] look_x;
		logic signed [31:0] look_y;
		logic signed [31:0] look_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} view_t;

endpackage

@@ src/ypcb_if.sv @@
// Valid/ready channels for body poses in and camera bases out.
interface ypcb_pose_if;
	logic             valid;
	logic             ready;
	ypcb_pkg::pose_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ypcb_view_if;
	logic             valid;
	logic             ready;
	ypcb_pkg::view_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/yaw_pitch_camera_basis_top.sv @@
// Top level of the yaw/pitch camera basis block.
//
// pose (sink): body position (Q15.16), yaw and signed pitch in binary angle
// units, 65536 to the turn. view (source): eye point, look target (eye plus
// forward) and up vector in Q1.14. One view per pose, in order.
// Config: wr_en/wr_index/wr_data write eye offset x, y, z (indexes 0..2);
// other indexes are dropped. Write only while no transfer is in flight.
//
// Sine and cosine of both angles come from a chain of ROTATION_STAGES CORDIC
// cells, one micro-rotation each, followed by three stages: quadrant fold and
// rounding, products, final sums into the output register.
// Throughput: one pose per cycle. The whole pipeline advances together;
// when a result sits in the output register and view.ready is low, the pipe
// freezes and pose.ready drops in the same cycle.
// Reset clears all valid flags and the offsets; payload registers are not reset.
module yaw_pitch_camera_basis_top #(
	parameter int ROTATION_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	ypcb_pose_if.sink         pose,
	ypcb_view_if.source       view,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data
);
	import ypcb_pkg::*;

	logic signed [31:0] offset_x_q, offset_y_q, offset_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EYE_OFFSET_X: offset_x_q <= wr_data;
				REG_EYE_OFFSET_Y: offset_y_q <= wr_data;
				REG_EYE_OFFSET_Z: offset_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being drained
	logic en;
	assign en         = !view.valid || view.ready;
	assign pose.ready = en;

	logic               chain_valid [0:ROTATION_STAGES];
	lane_t              chain       [0:ROTATION_STAGES];
	logic signed [15:0] pitch_clamped;

	always_comb begin
		if (pose.data.pitch_angle > PITCH_LIMIT) begin
			pitch_clamped = PITCH_LIMIT;
		end else if (pose.data.pitch_angle < -PITCH_LIMIT) begin
			pitch_clamped = -PITCH_LIMIT;
		end else begin
			pitch_clamped = pose.data.pitch_angle;
		end

		// phase = angle << 16; top two bits pick the quadrant
		chain[0].yaw.x      = CORDIC_X0;
		chain[0].yaw.y      = '0;
		chain[0].yaw.z      = {2'b00, pose.data.yaw_angle[13:0], 16'h0000};
		chain[0].yaw_quad   = pose.data.yaw_angle[15:14];
		chain[0].pitch.x    = CORDIC_X0;
		chain[0].pitch.y    = '0;
		chain[0].pitch.z    = {2'b00, pitch_clamped[13:0], 16'h0000};
		chain[0].pitch_quad = pitch_clamped[15:14];
		chain[0].eye.x      = pose.data.body_x + offset_x_q;
		chain[0].eye.y      = pose.data.body_y + offset_y_q;
		chain[0].eye.z      = pose.data.body_z + offset_z_q;
	end

	assign chain_valid[0] = pose.valid;

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		ypcb_cell #(
			.STAGE(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_in(chain_valid[i]),
			.lane_in (chain[i]),
			.valid_q (chain_valid[i+1]),
			.lane_q  (chain[i+1])
		);
	end

	ypcb_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_in(chain_valid[ROTATION_STAGES]),
		.lane_in (chain[ROTATION_STAGES]),
		.valid_s3(view.valid),
		.res_s3  (view.data)
	);

	a_accept_enters_chain: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.ready |=> chain_valid[1])
		else $error("accepted pose did not enter the first cell");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		view.valid && !view.ready |-> !pose.ready)
		else $error("pose taken while result held");

	a_up_y_not_positive: assert property (@(posedge clk) disable iff (!arst_n)
		view.valid |-> view.data.up_y <= 16'sd0)
		else $error("up_y positive although pitch is clamped");

	a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> chain_valid[ROTATION_STAGES] == $past(chain_valid[ROTATION_STAGES]))
		else $error("chain moved during a stall");

endmodule

@@ src/ypcb_cell.sv @@
// One CORDIC rotation cell: rotates yaw and pitch vectors by one micro-angle.
module ypcb_cell #(
	parameter int STAGE = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ypcb_pkg::lane_t lane_in,
	output logic            valid_q,
	output ypcb_pkg::lane_t lane_q
);
	import ypcb_pkg::*;

	localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_TURNS[STAGE]);

	function automatic rot_t rotate(input rot_t r);
		rot_t n;
		if (!r.z[ZW-1]) begin
			n.x = r.x - (r.y >>> STAGE);
			n.y = r.y + (r.x >>> STAGE);
			n.z = r.z - ATAN_STEP;
		end else begin
			n.x = r.x + (r.y >>> STAGE);
			n.y = r.y - (r.x >>> STAGE);
			n.z = r.z + ATAN_STEP;
		end
		return n;
	endfunction

	lane_t lane_d;

	always_comb begin
		lane_d       = lane_in;
		lane_d.yaw   = rotate(lane_in.yaw);
		lane_d.pitch = rotate(lane_in.pitch);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

endmodule

@@ src/ypcb_post.sv @@
// Quadrant fold and Q1.14 rounding, basis products, then the eye/look sums.
module ypcb_post (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ypcb_pkg::lane_t lane_in,
	output logic            valid_s3,
	output ypcb_pkg::view_t res_s3
);
	import ypcb_pkg::*;

	localparam int VW = XW + 1;
	localparam logic signed [VW-1:0] Q14_ONE  = VW'(16384);
	localparam logic signed [VW-1:0] HALF_LSB = VW'(32768);

	// round half up from Q1.30 to Q1.14, clipped to plus/minus one
	function automatic logic signed [15:0] to_q14(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] r;
		r = (v + HALF_LSB) >>> 16;
		if (r > Q14_ONE) begin
			r = Q14_ONE;
		end else if (r < -Q14_ONE) begin
			r = -Q14_ONE;
		end
		return 16'(r);
	endfunction

	// (cos, sin) from the first-quadrant vector and the quadrant code
	function automatic logic [31:0] fold(input rot_t r, input logic [1:0] quad);
		logic signed [VW-1:0] xe;
		logic signed [VW-1:0] ye;
		logic signed [VW-1:0] c;
		logic signed [VW-1:0] s;
		xe = VW'(r.x);
		ye = VW'(r.y);
		case (quad)
			QUAD_I: begin
				c = xe;
				s = ye;
			end
			QUAD_II: begin
				c = -ye;
				s = xe;
			end
			QUAD_III: begin
				c = -xe;
				s = -ye;
			end
			default: begin
				c = ye;
				s = -xe;
			end
		endcase
		return {to_q14(c), to_q14(s)};
	endfunction

	logic               valid_s1;
	logic signed [15:0] cy_s1, sy_s1, cp_s1, sp_s1;
	vec3_t              eye_s1;

	logic               valid_s2;
	logic signed [31:0] fx_prod_s2, fz_prod_s2, ux_prod_s2, uz_prod_s2;
	logic signed [15:0] cp_s2, sp_s2;
	vec3_t              eye_s2;

	logic signed [31:0] fx, fy, fz;
	view_t              res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{cy_s1, sy_s1} <= fold(lane_in.yaw, lane_in.yaw_quad);
			{cp_s1, sp_s1} <= fold(lane_in.pitch, lane_in.pitch_quad);
			eye_s1         <= lane_in.eye;

			fx_prod_s2 <= 32'(cp_s1) * 32'(sy_s1);
			fz_prod_s2 <= 32'(cp_s1) * 32'(cy_s1);
			ux_prod_s2 <= 32'(sy_s1) * 32'(sp_s1);
			uz_prod_s2 <= 32'(cy_s1) * 32'(sp_s1);
			cp_s2      <= cp_s1;
			sp_s2      <= sp_s1;
			eye_s2     <= eye_s1;

			res_s3 <= res_d;
		end
	end

	always_comb begin
		fx = (fx_prod_s2 + 32'sd2048) >>> 12;
		fz = (fz_prod_s2 + 32'sd2048) >>> 12;
		fy = 32'(sp_s2) <<< 2;

		res_d.eye_x  = eye_s2.x;
		res_d.eye_y  = eye_s2.y;
		res_d.eye_z  = eye_s2.z;
		res_d.look_x = eye_s2.x + fx;
		res_d.look_y = eye_s2.y + fy;
		res_d.look_z = eye_s2.z + fz;
		res_d.up_x   = 16'((ux_prod_s2 + 32'sd8192) >>> 14);
		res_d.up_y   = -cp_s2;
		res_d.up_z   = 16'((uz_prod_s2 + 32'sd8192) >>> 14);
	end

endmodule
